>>> rtl/rrip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrip_pkg
// Shared types and constants of the re-reference interval replacement unit.
// ----------------------------------------------------------------------------
package rrip_pkg;

  // Default geometry.
  localparam int DEF_NUM_SETS = 2048;
  localparam int DEF_NUM_WAYS = 16;
  localparam int DEF_SIG_BITS = 6;

  // Widths of the item fields.
  localparam int SET_IN_W  = 11;
  localparam int WAY_IN_W  = 4;
  localparam int ADDR_IN_W = 64;
  localparam int PC_IN_W   = 64;
  localparam int VICTIM_W  = 4;
  localparam int BLOCK_W   = 32;
  localparam int IN_DATA_W = 144;
  localparam int OUT_DATA_W = 8;

  // Bit positions inside in_tdata.
  localparam int TD_SET_LSB  = 0;
  localparam int TD_WAY_LSB  = 11;
  localparam int TD_ADDR_LSB = 15;
  localparam int TD_PC_LSB   = 79;
  localparam int TD_HIT_BIT  = 143;

  // Byte address to block address, and the fold of the program counter.
  localparam int BLOCK_LSB = 6;
  localparam int SIG_SHIFT = 6;

  // The set index is reduced in two halves; steps at or above this shift
  // are done when the item is taken in.
  localparam int RED_SPLIT = 5;

  localparam logic [1:0] MAX_RRV = 2'd3;

  // Request kinds carried on in_tuser.
  localparam logic REQ_VICTIM = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } rrip_state_t;

  typedef struct packed {
    logic clr_we;   // write reset contents at the sweep address
    logic capture;  // take the accepted item into the datapath
    logic rd_en;    // read both stores
    logic commit;   // write back and, for a victim request, load the result
  } rrip_cmd_t;

  typedef struct packed {
    logic clr_last;  // sweep is at its last entry
    logic is_update; // held item is an update request
    logic out_busy;  // result register full and not taken this cycle
  } rrip_stat_t;

endpackage

>>> rtl/rrip_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrip_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rrip_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/rrip_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrip_ctrl
// Sequencer: clearing sweep after reset, then take, read and execute for
// each item.
// ----------------------------------------------------------------------------
module rrip_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  rrip_pkg::rrip_stat_t   stat,
  output rrip_pkg::rrip_cmd_t    cmd
);

  rrip_pkg::rrip_state_t state_r;
  rrip_pkg::rrip_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrip_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      rrip_pkg::ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (stat.clr_last) begin
          state_nxt = rrip_pkg::ST_IDLE;
        end
      end
      rrip_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = rrip_pkg::ST_READ;
        end
      end
      rrip_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = rrip_pkg::ST_EXEC;
      end
      rrip_pkg::ST_EXEC: begin
        // A victim result waits here until the result register is free.
        if (stat.is_update || !stat.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = rrip_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rrip_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

>>> rtl/rrip_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrip_dp
// Datapath: set reduction, set store (re-reference values, stream flag and
// last block per set), reuse counter store, victim search and update logic.
// ----------------------------------------------------------------------------
module rrip_dp #(
  parameter int NUM_SETS = rrip_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS = rrip_pkg::DEF_NUM_WAYS,
  parameter int SIG_BITS = rrip_pkg::DEF_SIG_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rrip_pkg::rrip_cmd_t               cmd,
  output rrip_pkg::rrip_stat_t              stat,
  input  logic [rrip_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rrip_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int SET_AW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int SIG_DEPTH = 1 << SIG_BITS;
  localparam int CLR_DEPTH = (NUM_SETS > SIG_DEPTH) ? NUM_SETS : SIG_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int WAY_W     = $clog2(NUM_WAYS);
  localparam int BW        = rrip_pkg::BLOCK_W;
  localparam int ROW_W     = 2 * NUM_WAYS + BW + 1;
  localparam int STRM_BIT  = BW;
  localparam int RRV_LSB   = BW + 1;
  localparam int SW        = rrip_pkg::SET_IN_W;

  // Held item.
  logic                 req_r;
  logic [SW-1:0]        red_r;
  logic [3:0]           way_r;
  logic [BW-1:0]        blk_r;
  logic [SIG_BITS-1:0]  sig_r;
  logic                 hit_r;

  logic [CLR_W-1:0]     clr_cnt_r;
  logic                 out_valid_r;
  logic [rrip_pkg::VICTIM_W-1:0] out_way_r;

  logic [SW-1:0]        red_hi;
  logic [SW-1:0]        red_lo;
  logic [rrip_pkg::PC_IN_W-1:0] pc_fold;

  logic [SET_AW-1:0]    set_addr;
  logic                 set_we;
  logic [ROW_W-1:0]     set_wdata;
  logic [ROW_W-1:0]     set_rdata;
  logic                 sig_we;
  logic [SIG_BITS-1:0]  sig_addr;
  logic [2:0]           sig_wdata;
  logic [2:0]           sig_rdata;

  // Victim side.
  logic [1:0]           rrv [NUM_WAYS];
  logic                 any3;
  logic                 any2;
  logic                 any1;
  logic [1:0]           top;
  logic [1:0]           add;
  logic [WAY_W-1:0]     first;
  logic [2*NUM_WAYS-1:0] aged_row;

  // Update side.
  logic [BW-1:0]        prev;
  logic [BW-1:0]        diff;
  logic                 strm_nxt;
  logic [1:0]           cnt_nxt;
  logic [1:0]           ins;
  logic [1:0]           line_val;
  logic [2*NUM_WAYS-1:0] upd_row;

  // ---- set index reduction, high half when the item is taken in ----------
  always_comb begin
    red_hi = in_tdata[rrip_pkg::TD_SET_LSB +: SW];
    for (int k = SW - 1; k >= rrip_pkg::RED_SPLIT; k--) begin
      if ({{(32-SW){1'b0}}, red_hi} >= (32'(NUM_SETS) << k)) begin
        red_hi = red_hi - SW'(32'(NUM_SETS) << k);
      end
    end
  end

  always_comb begin
    red_lo = red_r;
    for (int k = rrip_pkg::RED_SPLIT - 1; k >= 0; k--) begin
      if ({{(32-SW){1'b0}}, red_lo} >= (32'(NUM_SETS) << k)) begin
        red_lo = red_lo - SW'(32'(NUM_SETS) << k);
      end
    end
  end

  assign pc_fold = in_tdata[rrip_pkg::TD_PC_LSB +: rrip_pkg::PC_IN_W]
                 ^ (in_tdata[rrip_pkg::TD_PC_LSB +: rrip_pkg::PC_IN_W] >> rrip_pkg::SIG_SHIFT);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_tuser;
      red_r <= red_hi;
      way_r <= in_tdata[rrip_pkg::TD_WAY_LSB +: rrip_pkg::WAY_IN_W];
      blk_r <= in_tdata[rrip_pkg::TD_ADDR_LSB + rrip_pkg::BLOCK_LSB +: BW];
      sig_r <= pc_fold[SIG_BITS-1:0];
      hit_r <= in_tdata[rrip_pkg::TD_HIT_BIT];
    end
  end

  // ---- clearing sweep counter -------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we && !stat.clr_last) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // ---- victim search and ageing -----------------------------------------
  always_comb begin
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      rrv[w] = set_rdata[RRV_LSB + 2*w +: 2];
      any3   = any3 | (rrv[w] == 2'd3);
      any2   = any2 | (rrv[w] == 2'd2);
      any1   = any1 | (rrv[w] == 2'd1);
    end
    top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
    add = rrip_pkg::MAX_RRV - top;
    // Lowest way holding the largest value.
    first = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rrv[w] == top) begin
        first = WAY_W'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged_row[2*w +: 2] = rrv[w] + add;
    end
  end

  // ---- stream detection, training and line value -------------------------
  assign prev = set_rdata[BW-1:0];
  assign diff = blk_r - prev;

  always_comb begin
    strm_nxt = set_rdata[STRM_BIT];
    if (prev != '0) begin
      if (diff == BW'(1) || diff == '1) begin
        strm_nxt = 1'b1;
      end else if (diff != '0) begin
        strm_nxt = 1'b0;
      end
    end

    if (sig_rdata[2]) begin
      cnt_nxt = sig_rdata[1:0];
      if (hit_r && sig_rdata[1:0] != 2'd3) begin
        cnt_nxt = sig_rdata[1:0] + 2'd1;
      end else if (!hit_r && sig_rdata[1:0] != 2'd0) begin
        cnt_nxt = sig_rdata[1:0] - 2'd1;
      end
    end else begin
      cnt_nxt = hit_r ? 2'd2 : 2'd0;
    end

    if (strm_nxt) begin
      ins = rrip_pkg::MAX_RRV;
    end else if (cnt_nxt[1]) begin
      ins = 2'd0;
    end else if (cnt_nxt == 2'd1) begin
      ins = 2'd1;
    end else begin
      ins = 2'd2;
    end
    line_val = hit_r ? 2'd0 : ins;

    // A way beyond the set matches no slot and leaves the row as it was.
    upd_row = set_rdata[RRV_LSB +: 2*NUM_WAYS];
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (5'(w) == {1'b0, way_r}) begin
        upd_row[2*w +: 2] = line_val;
      end
    end
  end

  // ---- store ports -------------------------------------------------------
  always_comb begin
    set_addr  = SET_AW'(red_lo);
    set_we    = 1'b0;
    set_wdata = set_rdata;
    sig_addr  = sig_r;
    sig_we    = 1'b0;
    sig_wdata = {1'b1, cnt_nxt};
    if (cmd.clr_we) begin
      set_addr  = SET_AW'(clr_cnt_r);
      sig_addr  = SIG_BITS'(clr_cnt_r);
      set_we    = ({{(32-CLR_W){1'b0}}, clr_cnt_r} < 32'(NUM_SETS));
      sig_we    = ({{(32-CLR_W){1'b0}}, clr_cnt_r} < 32'(SIG_DEPTH));
      set_wdata = {{NUM_WAYS{rrip_pkg::MAX_RRV}}, 1'b0, {BW{1'b0}}};
      sig_wdata = '0;
    end else if (cmd.commit) begin
      set_we = 1'b1;
      if (req_r == rrip_pkg::REQ_UPDATE) begin
        set_wdata = {upd_row, strm_nxt, blk_r};
        sig_we    = 1'b1;
      end else begin
        set_wdata = {aged_row, set_rdata[STRM_BIT:0]};
      end
    end
  end

  rrip_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS),
    .ADDR_W(SET_AW)
  ) u_set_ram (
    .clk  (clk),
    .we   (set_we),
    .waddr(set_addr),
    .wdata(set_wdata),
    .re   (cmd.rd_en),
    .raddr(set_addr),
    .rdata(set_rdata)
  );

  rrip_ram #(
    .WIDTH (3),
    .DEPTH (SIG_DEPTH),
    .ADDR_W(SIG_BITS)
  ) u_sig_ram (
    .clk  (clk),
    .we   (sig_we),
    .waddr(sig_addr),
    .wdata(sig_wdata),
    .re   (cmd.rd_en),
    .raddr(sig_addr),
    .rdata(sig_rdata)
  );

  // ---- result register ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit && req_r == rrip_pkg::REQ_VICTIM) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && req_r == rrip_pkg::REQ_VICTIM) begin
      out_way_r <= rrip_pkg::VICTIM_W'(first);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(rrip_pkg::OUT_DATA_W-rrip_pkg::VICTIM_W){1'b0}}, out_way_r};

  assign stat.clr_last  = (clr_cnt_r == CLR_W'(CLR_DEPTH - 1));
  assign stat.is_update = (req_r == rrip_pkg::REQ_UPDATE);
  assign stat.out_busy  = out_valid_r && !out_tready;

endmodule

>>> rtl/rrip_replacement_with_reuse_predictor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrip_replacement_with_reuse_predictor_unit
// Cache replacement state with 2-bit re-reference values, a signature-indexed
// reuse predictor and per-set stream detection.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  --------+-----------+----------------------------------------------------
//  in_     | input     | tuser: req_type; tdata: set_index, way, phys_addr,
//          |           | pc, hit
//  out_    | output    | tdata: victim_way (one item per victim request)
//
//  Each item passes in turn through accept, store read, and execute and
//  write-back; the next item is accepted only after that write-back.
//  A victim request stays in execute while the result register is still full.
//  After reset a clearing sweep over max(NUM_SETS, 2**SIG_BITS) entries (2048 by
//  default) writes both stores; no item is accepted until it ends.
// ----------------------------------------------------------------------------
module rrip_replacement_with_reuse_predictor_unit #(
  parameter int NUM_SETS = rrip_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS = rrip_pkg::DEF_NUM_WAYS,
  parameter int SIG_BITS = rrip_pkg::DEF_SIG_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // set_index[10:0], way[14:11], phys_addr[78:15], pc[142:79], hit[143]
  input  logic [rrip_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type[0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // victim_way[3:0], zero fill above
  output logic [rrip_pkg::OUT_DATA_W-1:0] out_tdata
);

  rrip_pkg::rrip_cmd_t  cmd;
  rrip_pkg::rrip_stat_t stat;

  rrip_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrip_dp #(
    .NUM_SETS(NUM_SETS),
    .NUM_WAYS(NUM_WAYS),
    .SIG_BITS(SIG_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule
